### rtl/bsa_pkg.sv
// Shared types, constants, microcode table and helpers of the slot allocator.
`default_nettype none

package bsa_pkg;

	localparam int NUM_WORDS_DEF = 8;
	localparam int WORD_BITS_DEF = 32;

	localparam int ACT_W     = 3;
	localparam int SLOT_W    = 8;
	localparam int RANK_W    = 8;
	localparam int IDX_W     = 8;
	localparam int IDX_MAX   = 255;
	localparam int CAP_W     = 9;
	localparam int CAP_RESET = 256;
	localparam int CNT_OUT_W = 9;
	localparam int CNT_MAX   = 511;

	// widest word the popcount helper takes
	localparam int POP_W  = 64;
	localparam int POPC_W = $clog2(POP_W + 1);

	localparam int UPC_W = 4;

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE  = 3'd0,
		ACT_ALLOC  = 3'd1,
		ACT_CLEAR  = 3'd2,
		ACT_READ   = 3'd3,
		ACT_COUNT  = 3'd4,
		ACT_SELECT = 3'd5
	} action_t;

	typedef enum logic [3:0] {
		U_LOC,        // step toward the addressed word
		U_ACCESS,     // read or write one bit
		U_SESCAN,     // skip words whose set bits lie below the rank
		U_LOAD_WORD,  // load the word for the in-word select
		U_HALVE,      // one level of the in-word binary search
		U_RESULT,     // form the index, set the bit on allocate
		U_ALSCAN,     // skip full words
		U_LOAD_INV,   // load the free bits for the in-word search
		U_FINISH,     // present the result word
		U_CLEAR       // drop every slot
	} uop_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NOFIT,
		C_MISS_NOTLAST,
		C_MISS,
		C_LVL_NZ,
		C_FULL_NOTLAST,
		C_NOTFULL
	} cond_t;

	typedef logic [UPC_W-1:0] upc_t;

	localparam upc_t STEP_LOC     = 4'd0;
	localparam upc_t STEP_ACC     = 4'd1;
	localparam upc_t STEP_SE_SCAN = 4'd2;
	localparam upc_t STEP_SE_CHK  = 4'd3;
	localparam upc_t STEP_SRCH    = 4'd4;
	localparam upc_t STEP_RES     = 4'd5;
	localparam upc_t STEP_AL_SCAN = 4'd6;
	localparam upc_t STEP_AL_CHK  = 4'd7;
	localparam upc_t STEP_FIN     = 4'd8;
	localparam upc_t STEP_CLR     = 4'd9;

	// jump to tgt when cond holds, else fall through to the next step
	typedef struct packed {
		uop_t  uop;
		cond_t cond;
		upc_t  tgt;
	} ctrl_t;

	typedef struct packed {
		logic wr;
		logic clr;
	} mem_cmd_t;

	function automatic ctrl_t ucode(upc_t upc);
		ctrl_t c;
		unique case (upc)
			STEP_LOC:     c = '{uop: U_LOC,       cond: C_NOFIT,        tgt: STEP_LOC};
			STEP_ACC:     c = '{uop: U_ACCESS,    cond: C_ALWAYS,       tgt: STEP_FIN};
			STEP_SE_SCAN: c = '{uop: U_SESCAN,    cond: C_MISS_NOTLAST, tgt: STEP_SE_SCAN};
			STEP_SE_CHK:  c = '{uop: U_LOAD_WORD, cond: C_MISS,         tgt: STEP_FIN};
			STEP_SRCH:    c = '{uop: U_HALVE,     cond: C_LVL_NZ,       tgt: STEP_SRCH};
			STEP_RES:     c = '{uop: U_RESULT,    cond: C_ALWAYS,       tgt: STEP_FIN};
			STEP_AL_SCAN: c = '{uop: U_ALSCAN,    cond: C_FULL_NOTLAST, tgt: STEP_AL_SCAN};
			STEP_AL_CHK:  c = '{uop: U_LOAD_INV,  cond: C_NOTFULL,      tgt: STEP_SRCH};
			STEP_FIN:     c = '{uop: U_FINISH,    cond: C_ALWAYS,       tgt: STEP_FIN};
			STEP_CLR:     c = '{uop: U_CLEAR,     cond: C_ALWAYS,       tgt: STEP_FIN};
			default:      c = '{uop: U_FINISH,    cond: C_ALWAYS,       tgt: STEP_FIN};
		endcase
		return c;
	endfunction

	function automatic logic [POPC_W-1:0] popcount(logic [POP_W-1:0] w);
		logic [POPC_W-1:0] s;
		s = '0;
		for (int i = 0; i < POP_W; i++) begin
			s = s + POPC_W'(w[i]);
		end
		return s;
	endfunction

endpackage

`default_nettype wire

### rtl/bsa_word_mem.sv
// Slot map word store with per-word valid bits and a registered read port.
`default_nettype none

module bsa_word_mem #(
	parameter int NUM_WORDS = bsa_pkg::NUM_WORDS_DEF,
	parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF,
	localparam int ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bsa_pkg::mem_cmd_t    cmd,
	input  wire logic [ADDR_W-1:0]    waddr,
	input  wire logic [WORD_BITS-1:0] wdata,
	input  wire logic [ADDR_W-1:0]    raddr,
	output logic [WORD_BITS-1:0]      rword
);

	logic [WORD_BITS-1:0] mem_q [NUM_WORDS];
	logic [NUM_WORDS-1:0] vld_q;
	logic [WORD_BITS-1:0] rdata_q;
	logic                 rvld_q;
	logic                 byp;

	// forward a write to the word being read in the same cycle
	assign byp = cmd.wr && (waddr == raddr);

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= byp ? wdata : mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else if (cmd.clr) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (cmd.wr) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_q <= byp | vld_q[raddr];
		end
	end

	// a word never written reads as all free
	assign rword = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

### rtl/bitmap_slot_allocator_core.sv
// Top level of the bitmap slot allocator: microcode sequencer and datapath.
`default_nettype none

// Bitmap slot allocator. A command word is taken when start is high and busy
// is low; exactly one result word follows, shown for one cycle with done high,
// and the receiver cannot stall it. busy is high from the accepting edge until
// the edge that raises done, so a new command can be taken in the done cycle.
// The map is NUM_WORDS words of WORD_BITS bits held in a word store read once
// per cycle, and a short microprogram walks it one word per cycle. Count and
// unused codes go straight to the result; clear all drops every slot first;
// write bit and read bit step to the addressed word and access the bit, or
// finish at once if the slot is beyond the map; allocate skips full words,
// then searches the free bits of the first word with a free slot, or
// finishes when the map is full; select skips words whose set bits lie below
// the rank, then searches the word holding the sought bit, or finishes when
// too few bits are set. The word scan goes one word per step, then takes L
// halving steps, L = log2(WORD_BITS) rounded up, of a popcount search inside
// the chosen word. The set-bit count is kept in a running register, so
// set_count and map_empty cost no scan. The capacity register is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while the block
// is idle, which the block itself does not enforce.
module bitmap_slot_allocator_core #(
	parameter int NUM_WORDS = bsa_pkg::NUM_WORDS_DEF,
	parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [bsa_pkg::CAP_W-1:0]     cfg_wr_data,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [bsa_pkg::ACT_W-1:0]     action,
	input  wire logic [bsa_pkg::SLOT_W-1:0]    slot_index,
	input  wire logic                          bit_value,
	input  wire logic [bsa_pkg::RANK_W-1:0]    rank,
	output logic                               done,
	output logic [bsa_pkg::IDX_W-1:0]          found_index,
	output logic                               found,
	output logic                               bit_read,
	output logic [bsa_pkg::CNT_OUT_W-1:0]      set_count,
	output logic                               map_empty
);

	localparam int TOTAL     = NUM_WORDS * WORD_BITS;
	localparam int WP_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int LOG_WB    = $clog2(WORD_BITS);
	localparam int PW        = 1 << LOG_WB;
	localparam int LVL_W     = $clog2(LOG_WB);
	localparam int HC_W      = LOG_WB + 1;
	localparam int CNT_W     = $clog2(TOTAL + 1);
	localparam int CAP_W     = bsa_pkg::CAP_W;
	localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int REM_W     = bsa_pkg::SLOT_W;
	localparam int RC_W      = REM_W + 1;
	localparam int ACT_W     = bsa_pkg::ACT_W;
	localparam int IDX_W     = bsa_pkg::IDX_W;
	localparam int CNT_OUT_W = bsa_pkg::CNT_OUT_W;
	localparam int POP_W     = bsa_pkg::POP_W;

	// control registers
	logic                   busy_q, busy_d;
	bsa_pkg::upc_t          upc_q, upc_d;
	logic                   done_q, done_d;
	logic [WP_W-1:0]        wp_q, wp_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [CAP_W-1:0]       cap_q;

	// working and result registers
	logic [REM_W-1:0]       rem_q, rem_d;
	logic [LOG_WB-1:0]      off_q, off_d;
	logic [LVL_W-1:0]       lvl_q, lvl_d;
	logic [PW-1:0]          srch_q, srch_d;
	logic [ACT_W-1:0]       act_q, act_d;
	logic                   bval_q, bval_d;
	logic [IDX_W-1:0]       fidx_q, fidx_d;
	logic                   found_q, found_d;
	logic                   bitrd_q, bitrd_d;
	logic [CNT_OUT_W-1:0]   setcnt_q, setcnt_d;
	logic                   empty_q, empty_d;

	// datapath signals
	bsa_pkg::ctrl_t         ctl;
	bsa_pkg::upc_t          entry;
	bsa_pkg::mem_cmd_t      mcmd;
	logic [WORD_BITS-1:0]   cur_w;
	logic [WORD_BITS-1:0]   free_w;
	logic [WORD_BITS-1:0]   wdata;
	logic                   fit, last, full, miss, keep, lvl_nz, oor, take;
	logic [HC_W-1:0]        pc_w, lowcnt, hw;
	logic [PW-1:0]          lowmask;
	logic [CMP_W-1:0]       idx_c;
	logic                   idx_ok;

	bsa_word_mem #(
		.NUM_WORDS (NUM_WORDS),
		.WORD_BITS (WORD_BITS)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mcmd),
		.waddr  (wp_q),
		.wdata  (wdata),
		.raddr  (wp_d),
		.rword  (cur_w)
	);

	assign ctl = bsa_pkg::ucode(upc_q);

	// word-level tests
	assign fit    = RC_W'(rem_q) < RC_W'(WORD_BITS);
	assign last   = wp_q == WP_W'(NUM_WORDS - 1);
	assign full   = &cur_w;
	assign free_w = ~cur_w;
	assign pc_w   = HC_W'(bsa_pkg::popcount(POP_W'(cur_w)));
	assign miss   = RC_W'(rem_q) >= RC_W'(pc_w);
	assign lvl_nz = lvl_q != '0;
	assign oor    = CMP_W'(slot_index) >= CMP_W'(TOTAL);

	// one level of the in-word search: count the low half of the window
	assign hw = HC_W'(1) << lvl_q;
	always_comb begin
		for (int i = 0; i < PW; i++) begin
			lowmask[i] = HC_W'(i) < hw;
		end
	end
	assign lowcnt = HC_W'(bsa_pkg::popcount(POP_W'(srch_q & lowmask)));
	assign keep   = RC_W'(rem_q) < RC_W'(lowcnt);

	assign idx_c  = CMP_W'(wp_q) * CMP_W'(WORD_BITS) + CMP_W'(off_q);
	assign idx_ok = idx_c <= CMP_W'(bsa_pkg::IDX_MAX);

	// entry step for a new command
	always_comb begin
		unique case (action) inside
			bsa_pkg::ACT_WRITE,
			bsa_pkg::ACT_READ:   entry = oor ? bsa_pkg::STEP_FIN : bsa_pkg::STEP_LOC;
			bsa_pkg::ACT_ALLOC:  entry = bsa_pkg::STEP_AL_SCAN;
			bsa_pkg::ACT_CLEAR:  entry = bsa_pkg::STEP_CLR;
			bsa_pkg::ACT_SELECT: entry = bsa_pkg::STEP_SE_SCAN;
			default:             entry = bsa_pkg::STEP_FIN;
		endcase
	end

	// jump condition of the current step
	always_comb begin
		unique case (ctl.cond)
			bsa_pkg::C_ALWAYS:       take = 1'b1;
			bsa_pkg::C_NOFIT:        take = !fit;
			bsa_pkg::C_MISS_NOTLAST: take = miss && !last;
			bsa_pkg::C_MISS:         take = miss;
			bsa_pkg::C_LVL_NZ:       take = lvl_nz;
			bsa_pkg::C_FULL_NOTLAST: take = full && !last;
			bsa_pkg::C_NOTFULL:      take = !full;
			default:                 take = 1'b1;
		endcase
	end

	// next step
	always_comb begin
		upc_d = upc_q;
		if (!busy_q) begin
			if (start) begin
				upc_d = entry;
			end
		end else if (take) begin
			upc_d = ctl.tgt;
		end else begin
			upc_d = upc_q + 1'b1;
		end
	end

	// datapath controls from the current control word
	always_comb begin
		busy_d   = busy_q;
		done_d   = 1'b0;
		wp_d     = wp_q;
		cnt_d    = cnt_q;
		rem_d    = rem_q;
		off_d    = off_q;
		lvl_d    = lvl_q;
		srch_d   = srch_q;
		act_d    = act_q;
		bval_d   = bval_q;
		fidx_d   = fidx_q;
		found_d  = found_q;
		bitrd_d  = bitrd_q;
		setcnt_d = setcnt_q;
		empty_d  = empty_q;
		mcmd     = '0;
		wdata    = cur_w;
		if (!busy_q) begin
			if (start) begin
				busy_d  = 1'b1;
				act_d   = action;
				bval_d  = bit_value;
				rem_d   = (action == bsa_pkg::ACT_SELECT) ? rank : slot_index;
				fidx_d  = '0;
				found_d = 1'b0;
				bitrd_d = 1'b0;
			end
		end else begin
			unique case (ctl.uop)
				bsa_pkg::U_LOC: begin
					if (!fit) begin
						rem_d = rem_q - REM_W'(WORD_BITS);
						wp_d  = wp_q + 1'b1;
					end
				end
				bsa_pkg::U_ACCESS: begin
					if (act_q == bsa_pkg::ACT_WRITE) begin
						wdata[rem_q[LOG_WB-1:0]] = bval_q;
						mcmd.wr = 1'b1;
						if (bval_q && !cur_w[rem_q[LOG_WB-1:0]]) begin
							cnt_d = cnt_q + 1'b1;
						end else if (!bval_q && cur_w[rem_q[LOG_WB-1:0]]) begin
							cnt_d = cnt_q - 1'b1;
						end
					end else begin
						bitrd_d = cur_w[rem_q[LOG_WB-1:0]];
					end
				end
				bsa_pkg::U_SESCAN: begin
					if (miss && !last) begin
						rem_d = rem_q - REM_W'(pc_w);
						wp_d  = wp_q + 1'b1;
					end
				end
				bsa_pkg::U_LOAD_WORD: begin
					srch_d = PW'(cur_w);
					off_d  = '0;
					lvl_d  = LVL_W'(LOG_WB - 1);
				end
				bsa_pkg::U_HALVE: begin
					if (!keep) begin
						rem_d  = rem_q - REM_W'(lowcnt);
						srch_d = srch_q >> hw;
						off_d  = off_q + LOG_WB'(hw);
					end
					if (lvl_nz) begin
						lvl_d = lvl_q - 1'b1;
					end
				end
				bsa_pkg::U_RESULT: begin
					if (act_q == bsa_pkg::ACT_ALLOC) begin
						wdata   = cur_w | (WORD_BITS'(1) << off_q);
						mcmd.wr = 1'b1;
						cnt_d   = cnt_q + 1'b1;
						found_d = idx_ok && (idx_c < CMP_W'(cap_q));
					end else begin
						found_d = idx_ok;
					end
					fidx_d = found_d ? idx_c[IDX_W-1:0] : '0;
				end
				bsa_pkg::U_ALSCAN: begin
					if (full && !last) begin
						wp_d = wp_q + 1'b1;
					end
				end
				bsa_pkg::U_LOAD_INV: begin
					srch_d = PW'(free_w);
					rem_d  = '0;
					off_d  = '0;
					lvl_d  = LVL_W'(LOG_WB - 1);
				end
				bsa_pkg::U_FINISH: begin
					busy_d   = 1'b0;
					done_d   = 1'b1;
					wp_d     = '0;
					setcnt_d = (CMP_W'(cnt_q) > CMP_W'(bsa_pkg::CNT_MAX)) ?
					           CNT_OUT_W'(bsa_pkg::CNT_MAX) : CNT_OUT_W'(cnt_q);
					empty_d  = cnt_q == '0;
				end
				bsa_pkg::U_CLEAR: begin
					mcmd.clr = 1'b1;
					cnt_d    = '0;
				end
				default: begin
					busy_d = 1'b0;
					wp_d   = '0;
				end
			endcase
		end
	end

	// control state and the running count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q  <= bsa_pkg::STEP_FIN;
			done_q <= 1'b0;
			wp_q   <= '0;
			cnt_q  <= '0;
			cap_q  <= CAP_W'(bsa_pkg::CAP_RESET);
		end else begin
			busy_q <= busy_d;
			upc_q  <= upc_d;
			done_q <= done_d;
			wp_q   <= wp_d;
			cnt_q  <= cnt_d;
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
		end
	end

	// working and result words
	always_ff @(posedge clk) begin
		rem_q    <= rem_d;
		off_q    <= off_d;
		lvl_q    <= lvl_d;
		srch_q   <= srch_d;
		act_q    <= act_d;
		bval_q   <= bval_d;
		fidx_q   <= fidx_d;
		found_q  <= found_d;
		bitrd_q  <= bitrd_d;
		setcnt_q <= setcnt_d;
		empty_q  <= empty_d;
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign found_index = fidx_q;
	assign found       = found_q;
	assign bit_read    = bitrd_q;
	assign set_count   = setcnt_q;
	assign map_empty   = empty_q;

endmodule

`default_nettype wire
